// ===== hw/rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants for the ray / segment intersection datapath.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // digit width of the digit-per-stage multipliers
    localparam int MUL_DIGIT = 17;

    localparam int CFG_ADDR_W = 2;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    // configuration register indexes
    localparam t_cfg_addr REG_ASSUME_COPLANAR = 2'd0;
    localparam t_cfg_addr REG_SIGN_TOLERANCE  = 2'd1;
    localparam t_cfg_addr REG_T_MINIMUM       = 2'd2;
    localparam t_cfg_addr REG_U_MARGIN        = 2'd3;

endpackage

// ===== hw/rtl/rsi_mul.sv =====
// ----------------------------------------------------------------------------
// rsi_mul
// Pipelined signed multiplier, one DIG-bit digit of B per stage.
// ----------------------------------------------------------------------------
module rsi_mul #(
    parameter int WA  = 33,
    parameter int WB  = 33,
    parameter int DIG = rsi_pkg::MUL_DIGIT
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import rsi_pkg::*;

    localparam int STG = (WB + DIG - 1) / DIG;
    localparam int BP  = STG * DIG;
    localparam int PW  = WA + WB;

    logic signed [WA-1:0] r_a   [STG];
    logic signed [BP-1:0] r_b   [STG];
    logic signed [PW-1:0] r_acc [STG];

    for (genvar k = 0; k < STG; k++) begin : g_stg
        logic signed [WA-1:0]    a_k;
        logic signed [BP-1:0]    b_k;
        logic signed [PW-1:0]    acc_k;
        logic signed [DIG:0]     dig_k;
        logic signed [WA+DIG:0]  pp_k;
        logic signed [PW-1:0]    n_acc;

        if (k == 0) begin : g_first
            assign a_k   = i_a;
            assign b_k   = BP'(i_b);
            assign acc_k = '0;
        end else begin : g_next
            assign a_k   = r_a[k-1];
            assign b_k   = r_b[k-1];
            assign acc_k = r_acc[k-1];
        end

        // top digit carries the sign, lower digits are unsigned
        if (k == STG - 1) begin : g_top
            assign dig_k = (DIG+1)'($signed(b_k[BP-1 -: DIG]));
        end else begin : g_low
            assign dig_k = $signed({1'b0, b_k[k*DIG +: DIG]});
        end

        assign pp_k  = a_k * dig_k;
        assign n_acc = acc_k + (PW'(pp_k) <<< (k * DIG));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= a_k;
                r_b[k]   <= b_k;
                r_acc[k] <= n_acc;
            end
        end
    end

    assign o_p = r_acc[STG-1];

endmodule

// ===== hw/rtl/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module rsi_div #(
    parameter int NW = 153,
    parameter int DW = 138,
    parameter int QB = 35
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic          i_neg,
    output logic [QB-1:0] o_quot,
    output logic          o_ovf,
    output logic          o_neg
);
    localparam int RW = DW + QB;

    logic [RW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_ovf [QB+1];
    logic          r_neg [QB+1];

    // entry stage: quotient does not fit in QB bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= RW'(i_num) >= {i_den, QB'(0)};
            r_neg[0] <= i_neg;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_bit
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(r_den[j-1]) << (QB - j);
        assign ge  = r_rem[j-1] >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]   <= {r_q[j-1][QB-2:0], ge};
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end

        if (j < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? r_rem[j-1] - dsh : r_rem[j-1];
                    r_den[j] <= r_den[j-1];
                end
            end
        end
    end

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];
    assign o_neg  = r_neg[QB];

endmodule

// ===== hw/rtl/ray_segment_intersect_3d.sv =====
// ----------------------------------------------------------------------------
// ray_segment_intersect_3d
// Fixed-point ray / segment intersection test in three dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ray/segment pair per transaction; m_axis returns one
//   result (hit, ray parameter t, segment parameter u) per pair, in order.
//   Configuration registers are written through i_cfg_wr_en / i_cfg_addr /
//   i_cfg_wdata by the user only while no transaction is in flight (unchecked).
// Throughput: one pair per cycle, fully pipelined, except while stalled (see Stall).
// Pipeline: input differences, cross product multipliers (LC digit stages),
//   component differences, dot product multipliers (LD digit stages), sums,
//   divider operands, the two restoring dividers (QB = COORD_WIDTH+3 quotient
//   bits, which set most of the depth), range checks and the output register.
// Reset: synchronous, active low; clears all valid bits and restores the
//   register defaults (coplanar test on, tolerance 0, t_minimum 1, margin 1).
// Stall: when m_axis_tready is low the output register holds, one more result
//   drops into a skid register, then s_axis_tready falls and the whole
//   pipeline freezes; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_segment_intersect_3d #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    //        start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    // tdata: hit, ray_param, seg_param (lowest first)
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                       i_cfg_wr_en,
    input  rsi_pkg::t_cfg_addr                         i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]                     i_cfg_wdata
);
    import rsi_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int OUT_W = ((2*CW + 1 + 7) / 8) * 8;
    localparam int VW    = CW + 1;          // differences of coordinates
    localparam int CPW   = 2 * VW;          // cross product terms
    localparam int XW    = CPW + 1;         // cross product components
    localparam int DPW   = 2 * XW;          // dot product terms
    localparam int SW    = DPW + 2;         // dot product sums
    localparam int QB    = CW + 3;          // quotient magnitude bits
    localparam int NW    = SW + F;          // shifted numerator
    localparam int TW    = QB + 2;          // signed quotient
    localparam int LC    = (VW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LD    = (XW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int LQ    = QB + 1;
    localparam int LAT   = 1 + LC + 1 + LD + 1 + 1 + LQ + 1;

    localparam logic signed [TW-1:0] ONE_FIX = TW'(1) <<< F;
    localparam logic signed [TW-1:0] SAT_HI  = (TW'(1) <<< (CW - 1)) - TW'(1);
    localparam logic signed [TW-1:0] SAT_LO  = -(TW'(1) <<< (CW - 1));

    // ---------------- configuration ----------------
    logic          r_assume;
    logic [CW-2:0] r_tol;
    logic [CW-1:0] r_tmin;
    logic [CW-2:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assume <= 1'b0;
            r_tol    <= '0;
            r_tmin   <= CW'(1);
            r_margin <= (CW-1)'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_ASSUME_COPLANAR: r_assume <= i_cfg_wdata[0];
                REG_SIGN_TOLERANCE:  r_tol    <= i_cfg_wdata[CW-2:0];
                REG_T_MINIMUM:       r_tmin   <= i_cfg_wdata;
                REG_U_MARGIN:        r_margin <= i_cfg_wdata[CW-2:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // whole pipeline moves together; only a full skid register stops it
    logic en;
    logic r_sk_valid;
    logic r_vld [LAT];

    assign en            = !r_sk_valid;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // ---------------- stage 1: V = P - O, L = Q - P, D ----------------
    logic signed [VW-1:0] r_v [3];
    logic signed [VW-1:0] r_l [3];
    logic signed [VW-1:0] r_d [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i] <= VW'($signed(s_axis_tdata[(6+i)*CW +: CW]))
                        - VW'($signed(s_axis_tdata[i*CW +: CW]));
                r_l[i] <= VW'($signed(s_axis_tdata[(9+i)*CW +: CW]))
                        - VW'($signed(s_axis_tdata[(6+i)*CW +: CW]));
                r_d[i] <= VW'($signed(s_axis_tdata[(3+i)*CW +: CW]));
            end
        end
    end

    // ---------------- cross products X = VxL, N = DxL, Y = VxD ----------------
    logic signed [CPW-1:0] p_xa [3], p_xb [3];
    logic signed [CPW-1:0] p_na [3], p_nb [3];
    logic signed [CPW-1:0] p_ya [3], p_yb [3];

    for (genvar g = 0; g < 3; g++) begin : g_cross
        localparam int I1 = (g + 1) % 3;
        localparam int I2 = (g + 2) % 3;
        rsi_mul #(.WA(VW), .WB(VW)) u_xa (.i_clk, .i_en(en),
            .i_a(r_v[I1]), .i_b(r_l[I2]), .o_p(p_xa[g]));
        rsi_mul #(.WA(VW), .WB(VW)) u_xb (.i_clk, .i_en(en),
            .i_a(r_v[I2]), .i_b(r_l[I1]), .o_p(p_xb[g]));
        rsi_mul #(.WA(VW), .WB(VW)) u_na (.i_clk, .i_en(en),
            .i_a(r_d[I1]), .i_b(r_l[I2]), .o_p(p_na[g]));
        rsi_mul #(.WA(VW), .WB(VW)) u_nb (.i_clk, .i_en(en),
            .i_a(r_d[I2]), .i_b(r_l[I1]), .o_p(p_nb[g]));
        rsi_mul #(.WA(VW), .WB(VW)) u_ya (.i_clk, .i_en(en),
            .i_a(r_v[I1]), .i_b(r_d[I2]), .o_p(p_ya[g]));
        rsi_mul #(.WA(VW), .WB(VW)) u_yb (.i_clk, .i_en(en),
            .i_a(r_v[I2]), .i_b(r_d[I1]), .o_p(p_yb[g]));
    end

    // D rides alongside the cross product stages
    logic signed [VW-1:0] r_d_dly [LC][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_d_dly[0][i] <= r_d[i];
                for (int s = 1; s < LC; s++) r_d_dly[s][i] <= r_d_dly[s-1][i];
            end
        end
    end

    // ---------------- component differences ----------------
    logic signed [XW-1:0] r_x [3], r_n [3], r_y [3], r_dx [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_x[i]  <= XW'(p_xa[i]) - XW'(p_xb[i]);
                r_n[i]  <= XW'(p_na[i]) - XW'(p_nb[i]);
                r_y[i]  <= XW'(p_ya[i]) - XW'(p_yb[i]);
                r_dx[i] <= XW'(r_d_dly[LC-1][i]);
            end
        end
    end

    // ---------------- dot products ----------------
    logic signed [DPW-1:0] m_det [3], m_den [3], m_tn [3], m_un [3];

    for (genvar g = 0; g < 3; g++) begin : g_dot
        rsi_mul #(.WA(XW), .WB(XW)) u_det (.i_clk, .i_en(en),
            .i_a(r_x[g]), .i_b(r_dx[g]), .o_p(m_det[g]));
        rsi_mul #(.WA(XW), .WB(XW)) u_den (.i_clk, .i_en(en),
            .i_a(r_n[g]), .i_b(r_n[g]), .o_p(m_den[g]));
        rsi_mul #(.WA(XW), .WB(XW)) u_tn (.i_clk, .i_en(en),
            .i_a(r_x[g]), .i_b(r_n[g]), .o_p(m_tn[g]));
        rsi_mul #(.WA(XW), .WB(XW)) u_un (.i_clk, .i_en(en),
            .i_a(r_y[g]), .i_b(r_n[g]), .o_p(m_un[g]));
    end

    logic signed [SW-1:0] r_det, r_den, r_tn, r_un;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= SW'(m_det[0]) + SW'(m_det[1]) + SW'(m_det[2]);
            r_den <= SW'(m_den[0]) + SW'(m_den[1]) + SW'(m_den[2]);
            r_tn  <= SW'(m_tn[0])  + SW'(m_tn[1])  + SW'(m_tn[2]);
            r_un  <= SW'(m_un[0])  + SW'(m_un[1])  + SW'(m_un[2]);
        end
    end

    // ---------------- tolerance tests, divider operands ----------------
    logic signed [SW-1:0] tol_s, det_s, den_s;
    logic [SW-1:0]        tn_mag, un_mag;
    logic                 cop_fail, par_fail;

    always_comb begin
        tol_s    = SW'($signed({1'b0, r_tol}));
        det_s    = r_det >>> (2 * F);     // back to Q.F, floor
        den_s    = r_den >>> (3 * F);
        cop_fail = !r_assume && (det_s > tol_s || det_s < -tol_s);
        par_fail = den_s <= tol_s;
        tn_mag   = r_tn[SW-1] ? SW'(-r_tn) : SW'(r_tn);
        un_mag   = r_un[SW-1] ? SW'(-r_un) : SW'(r_un);
    end

    logic          r_rej;
    logic [NW-1:0] r_nt, r_nu;
    logic [SW-1:0] r_dv;
    logic          r_negt, r_negu;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rej  <= cop_fail || par_fail;
            r_nt   <= NW'(tn_mag) << F;
            r_nu   <= NW'(un_mag) << F;
            r_dv   <= r_den;
            r_negt <= r_tn[SW-1];
            r_negu <= r_un[SW-1];
        end
    end

    // ---------------- dividers ----------------
    logic [QB-1:0] q_t, q_u;
    logic          ovf_t, ovf_u, neg_t, neg_u;

    rsi_div #(.NW(NW), .DW(SW), .QB(QB)) u_div_t (
        .i_clk, .i_en(en), .i_num(r_nt), .i_den(r_dv), .i_neg(r_negt),
        .o_quot(q_t), .o_ovf(ovf_t), .o_neg(neg_t));

    rsi_div #(.NW(NW), .DW(SW), .QB(QB)) u_div_u (
        .i_clk, .i_en(en), .i_num(r_nu), .i_den(r_dv), .i_neg(r_negu),
        .o_quot(q_u), .o_ovf(ovf_u), .o_neg(neg_u));

    logic r_rej_dly [LQ];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rej_dly[0] <= r_rej;
            for (int s = 1; s < LQ; s++) r_rej_dly[s] <= r_rej_dly[s-1];
        end
    end

    // ---------------- range checks and saturation ----------------
    function automatic logic [CW-1:0] sat_f(input logic signed [TW-1:0] a);
        logic signed [TW-1:0] s;
        s = a;
        if (a > SAT_HI) s = SAT_HI;
        else if (a < SAT_LO) s = SAT_LO;
        return s[CW-1:0];
    endfunction

    logic [QB:0]          t_mag, u_mag;
    logic signed [TW-1:0] t_val, u_val, marg_s;
    logic                 t_ok, u_ok, hit;

    always_comb begin
        // quotients that overflow QB bits clamp to 2^QB in magnitude, far outside the u window
        t_mag  = ovf_t ? ((QB+1)'(1) << QB) : {1'b0, q_t};
        u_mag  = ovf_u ? ((QB+1)'(1) << QB) : {1'b0, q_u};
        t_val  = neg_t ? -TW'(t_mag) : TW'(t_mag);
        u_val  = neg_u ? -TW'(u_mag) : TW'(u_mag);
        marg_s = TW'($signed({1'b0, r_margin}));
        t_ok   = t_val >= TW'($signed(r_tmin));
        u_ok   = (u_val >= -marg_s) && (u_val <= ONE_FIX + marg_s);
        hit    = !r_rej_dly[LQ-1] && t_ok && u_ok;
    end

    logic          r_hit;
    logic [CW-1:0] r_t, r_u;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= hit;
            r_t   <= hit ? sat_f(t_val) : '0;
            r_u   <= hit ? sat_f(u_val) : '0;
        end
    end

    // ---------------- output register with skid ----------------
    logic [OUT_W-1:0] n_out;
    logic [OUT_W-1:0] r_out, r_sk;
    logic             r_out_valid;

    assign n_out = OUT_W'({r_u, r_t, r_hit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end
        end else if (r_vld[LAT-1]) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_sk_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (m_axis_tready) r_out <= r_sk;
        end else if (r_vld[LAT-1]) begin
            if (!r_out_valid || m_axis_tready) r_out <= n_out;
            else r_sk <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// ===== hw/rtl/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for ray_segment_intersect_3d, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
    localparam int CW = COORD_WIDTH;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a miss reports zero parameters
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2*CW:1] == '0)
        else $error("nonzero parameters without hit");

    // input side never blocked by an empty output
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind ray_segment_intersect_3d rsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
